[sv/ucsa_pkg.sv]
package ucsa_pkg;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_COMMA   = 8'd44;
    localparam logic [7:0] CHAR_PLUS    = 8'd43;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_VTAB    = 8'd11;
    localparam logic [7:0] CHAR_FFEED   = 8'd12;
    localparam logic [7:0] CHAR_CR      = 8'd13;

    // Magnitudes saturate here, which is enough to clamp to VALUE_MAX later.
    localparam logic [8:0] MAG_SAT   = 9'd256;
    localparam logic [8:0] VALUE_MAX = 9'd255;

    // floor(u * 180 / 510) for u in 0..510 equals (u * ANGLE_RECIP) >> ANGLE_SHIFT.
    localparam int          ANGLE_SHIFT = 16;
    localparam logic [14:0] ANGLE_RECIP = 15'd23136;

    typedef struct packed {
        logic signed [8:0] x_value;
        logic signed [8:0] y_value;
    } t_pair;

    function automatic logic signed [8:0] clamp_value(input logic neg, input logic [8:0] mag);
        logic [8:0] lim;
        lim = (mag > VALUE_MAX) ? VALUE_MAX : mag;
        return neg ? $signed(-lim) : $signed(lim);
    endfunction

endpackage

[sv/uart_pair_command_to_servo_angles.sv]
// Serial command line parser that turns "x,y" text into two servo angles.
// Input channel: one received byte per transfer on i_rx_byte, qualified by
// i_valid and held off by o_stall. Every byte can be taken in consecutive
// cycles; o_stall rises only while the internal result queue is full.
// A line ends at byte 10. Only the first LINE_CAPACITY-1 bytes of a line
// count, a zero byte ends the text early, and the first two comma-separated
// fields are read as signed decimal numbers with leading whitespace allowed.
// Output channel: one transfer per line on o_valid, held off by i_stall.
// It carries both values clamped to -255..255 and both angles 0..180.
// A newline's result is written into the queue and then loaded into the
// output register, from which it drives the output ports.
// Throughput: one byte per cycle while o_stall is low, and one line result
// per cycle when lines are as short as a single newline and i_stall is low;
// the angle multipliers sit in the output stage and do not limit the rate.
// When the receiver stalls, the output register holds its result and up to
// two further results wait in a two-entry queue; after that o_stall is raised
// until the receiver takes a transfer. Reset clears the parse state, the
// queue and the output valid, and the block starts at the head of a new line.
module uart_pair_command_to_servo_angles #(
    parameter int LINE_CAPACITY = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [8:0] o_x_value,
    output logic signed [8:0] o_y_value,
    output logic [7:0]        o_first_angle,
    output logic [7:0]        o_second_angle
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    ucsa_pkg::t_pair push_pair;
    ucsa_pkg::t_pair head_pair;

    // The front only ever needs queue space on a newline, but holding every
    // byte while the queue is full keeps the stall a plain decode of the queue count.
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    ucsa_front #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_pair    (push_pair)
    );

    ucsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .i_pop   (pop),
        .o_pair  (head_pair),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back stage loads the output register whenever the queue holds a result
    // and the register is empty or its result is being taken in the same cycle.
    ucsa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pair         (head_pair),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_x_value      (o_x_value),
        .o_y_value      (o_y_value),
        .o_first_angle  (o_first_angle),
        .o_second_angle (o_second_angle)
    );

endmodule

[sv/ucsa_front.sv]
module ucsa_front #(
    parameter int LINE_CAPACITY = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    output logic                o_push,
    output ucsa_pkg::t_pair     o_pair
);

    localparam int CW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(LINE_CAPACITY - 1);

    typedef enum logic [1:0] {PH_GAP, PH_SPACE, PH_NUM, PH_DONE} t_phase;

    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_sel, n_sel;
    t_phase        r_phase, n_phase;
    logic          r_x_neg, n_x_neg;
    logic [8:0]    r_x_mag, n_x_mag;
    logic          r_y_neg, n_y_neg;
    logic [8:0]    r_y_mag, n_y_mag;
    logic          r_ended, n_ended;

    logic          is_digit;
    logic          is_space;
    logic          is_sign;
    logic [8:0]    cur_mag;
    logic [11:0]   grown;
    logic [8:0]    next_mag;
    t_phase        ph;

    assign is_digit = (i_rx_byte >= ucsa_pkg::CHAR_ZERO) && (i_rx_byte <= ucsa_pkg::CHAR_NINE);
    assign is_space = (i_rx_byte == ucsa_pkg::CHAR_SPACE) || (i_rx_byte == ucsa_pkg::CHAR_TAB)
                   || (i_rx_byte == ucsa_pkg::CHAR_VTAB) || (i_rx_byte == ucsa_pkg::CHAR_FFEED)
                   || (i_rx_byte == ucsa_pkg::CHAR_CR);
    assign is_sign  = (i_rx_byte == ucsa_pkg::CHAR_PLUS) || (i_rx_byte == ucsa_pkg::CHAR_MINUS);
    assign cur_mag  = (r_sel == 2'd0) ? r_x_mag : r_y_mag;
    assign grown    = {3'b000, cur_mag} * 12'd10 + {4'b0000, i_rx_byte - ucsa_pkg::CHAR_ZERO};
    assign next_mag = (grown > {3'b000, ucsa_pkg::MAG_SAT}) ? ucsa_pkg::MAG_SAT : grown[8:0];

    assign o_push         = i_accept && (i_rx_byte == ucsa_pkg::CHAR_NEWLINE);
    assign o_pair.x_value = ucsa_pkg::clamp_value(r_x_neg, r_x_mag);
    assign o_pair.y_value = ucsa_pkg::clamp_value(r_y_neg, r_y_mag);

    always_comb begin
        n_count = r_count;
        n_sel   = r_sel;
        n_phase = r_phase;
        n_x_neg = r_x_neg;
        n_x_mag = r_x_mag;
        n_y_neg = r_y_neg;
        n_y_mag = r_y_mag;
        n_ended = r_ended;
        ph      = (r_phase == PH_GAP) ? PH_SPACE : r_phase;
        if (i_accept) begin
            if (i_rx_byte == ucsa_pkg::CHAR_NEWLINE) begin
                n_count = '0;
                n_sel   = 2'd0;
                n_phase = PH_GAP;
                n_x_neg = 1'b0;
                n_x_mag = '0;
                n_y_neg = 1'b0;
                n_y_mag = '0;
                n_ended = 1'b0;
            end else if (r_count < COUNT_LIMIT) begin
                n_count = r_count + 1'b1;
                if (!r_ended) begin
                    if (i_rx_byte == ucsa_pkg::CHAR_NUL) begin
                        n_ended = 1'b1;
                    end else if (r_sel != 2'd2) begin
                        if (i_rx_byte == ucsa_pkg::CHAR_COMMA) begin
                            if (r_phase != PH_GAP) begin
                                n_sel   = r_sel + 2'd1;
                                n_phase = PH_GAP;
                            end
                        end else if (is_digit) begin
                            if (ph != PH_DONE) begin
                                n_phase = PH_NUM;
                                if (r_sel == 2'd0) begin
                                    n_x_mag = next_mag;
                                end else begin
                                    n_y_mag = next_mag;
                                end
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end else if (ph == PH_SPACE && is_space) begin
                            n_phase = PH_SPACE;
                        end else if (ph == PH_SPACE && is_sign) begin
                            n_phase = PH_NUM;
                            if (r_sel == 2'd0) begin
                                n_x_neg = (i_rx_byte == ucsa_pkg::CHAR_MINUS);
                            end else begin
                                n_y_neg = (i_rx_byte == ucsa_pkg::CHAR_MINUS);
                            end
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sel   <= 2'd0;
            r_phase <= PH_GAP;
            r_x_neg <= 1'b0;
            r_x_mag <= '0;
            r_y_neg <= 1'b0;
            r_y_mag <= '0;
            r_ended <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sel   <= n_sel;
            r_phase <= n_phase;
            r_x_neg <= n_x_neg;
            r_x_mag <= n_x_mag;
            r_y_neg <= n_y_neg;
            r_y_mag <= n_y_mag;
            r_ended <= n_ended;
        end
    end

endmodule

[sv/ucsa_queue.sv]
module ucsa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ucsa_pkg::t_pair i_pair,
    input  logic            i_pop,
    output ucsa_pkg::t_pair o_pair,
    output logic            o_full,
    output logic            o_empty
);

    ucsa_pkg::t_pair r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_pair  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from an empty queue");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push && r_count == 2'd1) |=> o_empty)
        else $error("queue not empty after last entry left");

endmodule

[sv/ucsa_back.sv]
module ucsa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ucsa_pkg::t_pair   i_pair,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic signed [8:0] o_x_value,
    output logic signed [8:0] o_y_value,
    output logic [7:0]        o_first_angle,
    output logic [7:0]        o_second_angle
);

    logic              r_valid;
    logic signed [8:0] r_x;
    logic signed [8:0] r_y;
    logic [7:0]        r_a1;
    logic [7:0]        r_a2;

    logic [8:0]  x_off;
    logic [8:0]  y_off;
    logic [23:0] x_prod;
    logic [23:0] y_prod;

    // Shift the signed value up by 255 so the angle map works on 0..510.
    assign x_off  = 9'($signed({i_pair.x_value[8], i_pair.x_value}) + 10'sd255);
    assign y_off  = 9'($signed({i_pair.y_value[8], i_pair.y_value}) + 10'sd255);
    assign x_prod = {15'd0, x_off} * {9'd0, ucsa_pkg::ANGLE_RECIP};
    assign y_prod = {15'd0, y_off} * {9'd0, ucsa_pkg::ANGLE_RECIP};

    assign o_pop          = !i_empty && (!r_valid || !i_stall);
    assign o_valid        = r_valid;
    assign o_x_value      = r_x;
    assign o_y_value      = r_y;
    assign o_first_angle  = r_a1;
    assign o_second_angle = r_a2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x  <= i_pair.x_value;
            r_y  <= i_pair.y_value;
            r_a1 <= x_prod[ucsa_pkg::ANGLE_SHIFT +: 8];
            r_a2 <= y_prod[ucsa_pkg::ANGLE_SHIFT +: 8];
        end
    end

endmodule
